// ===== src/dtlv_pkg.sv =====
package dtlv_pkg;

	// Widths of the input fields and of the packed slave-side data word.
	localparam int unsigned TAG_W      = 8;
	localparam int unsigned LEN_W      = 31;
	localparam int unsigned INT_W      = 32;
	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned OUT_DATA_W = 8;

	// Longest encoding of one item, in bytes.
	localparam int unsigned MAX_BYTES = 6;

	typedef logic [2:0] byte_cnt_t;

	// Item modes.
	localparam logic MODE_HEADER  = 1'b0;
	localparam logic MODE_INTEGER = 1'b1;

	// DER constants.
	localparam logic [7:0] INTEGER_TAG    = 8'h02;
	localparam logic [7:0] SHORT_FORM_MAX = 8'h7f;
	localparam logic [7:0] LONG_FORM_BASE = 8'h80;

	typedef struct packed {
		logic signed [INT_W-1:0] integer_value;
		logic [LEN_W-1:0]        body_length;
		logic [TAG_W-1:0]        tag;
		logic                    mode;
	} item_t;

	// Encoded bytes in transmission order, entry 0 goes out first.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		byte_cnt_t                 count;
	} enc_seq_t;

endpackage

// ===== src/dtlv_encoder.sv =====
module dtlv_encoder (
	input  dtlv_pkg::item_t    item,
	output dtlv_pkg::enc_seq_t seq
);
	import dtlv_pkg::*;

	logic [31:0] len_w;
	logic [31:0] mag;
	logic [2:0]  nb_len;
	logic [2:0]  nb_int;
	logic [2:0]  nb;
	logic [2:0]  pad;
	logic [31:0] src;
	logic [31:0] aligned;
	logic        short_form;

	assign len_w      = {1'b0, item.body_length};
	assign short_form = (len_w <= {24'd0, SHORT_FORM_MAX});

	// Fewest bytes for the unsigned length.
	always_comb begin
		if (len_w[31:24] != 8'd0) begin
			nb_len = 3'd4;
		end else if (len_w[23:16] != 8'd0) begin
			nb_len = 3'd3;
		end else if (len_w[15:8] != 8'd0) begin
			nb_len = 3'd2;
		end else begin
			nb_len = 3'd1;
		end
	end

	// A negative value has the same minimal width as its complement.
	assign mag = item.integer_value[31] ? ~item.integer_value : item.integer_value;

	always_comb begin
		if (mag[30:23] != 8'd0) begin
			nb_int = 3'd4;
		end else if (mag[22:15] != 8'd0) begin
			nb_int = 3'd3;
		end else if (mag[14:7] != 8'd0) begin
			nb_int = 3'd2;
		end else begin
			nb_int = 3'd1;
		end
	end

	assign nb  = (item.mode == MODE_INTEGER) ? nb_int : nb_len;
	assign src = (item.mode == MODE_INTEGER) ? item.integer_value : len_w;
	// Move the most significant byte in use to the top of the word.
	assign pad     = 3'd4 - nb;
	assign aligned = src << {pad, 3'b000};

	always_comb begin
		seq.bytes = '0;
		if (item.mode == MODE_INTEGER) begin
			seq.bytes[0] = INTEGER_TAG;
			seq.bytes[1] = {5'd0, nb};
			for (int k = 0; k < 4; k++) begin
				seq.bytes[k+2] = aligned[31-8*k -: 8];
			end
			seq.count = nb + 3'd2;
		end else if (short_form) begin
			seq.bytes[0] = item.tag;
			seq.bytes[1] = len_w[7:0];
			seq.count    = 3'd2;
		end else begin
			seq.bytes[0] = item.tag;
			seq.bytes[1] = LONG_FORM_BASE | {5'd0, nb};
			for (int k = 0; k < 4; k++) begin
				seq.bytes[k+2] = aligned[31-8*k -: 8];
			end
			seq.count = nb + 3'd2;
		end
		// Slots beyond the count are never sent; clear them for tidiness.
		for (int k = 0; k < MAX_BYTES; k++) begin
			if (3'(k) >= seq.count) begin
				seq.bytes[k] = 8'd0;
			end
		end
	end

endmodule

// ===== src/dtlv_serializer.sv =====
module dtlv_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dtlv_pkg::enc_seq_t in_seq,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast
);
	import dtlv_pkg::*;

	logic [MAX_BYTES-1:0][7:0] seq_q;
	byte_cnt_t                 cnt_q;
	logic                      take;
	logic                      load;

	assign take     = m_tvalid && m_tready;
	// The buffer can take a new sequence once its last byte is leaving.
	assign in_ready = (cnt_q == 3'd0) || (take && cnt_q == 3'd1);
	assign load     = in_ready && in_valid;

	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tdata  = seq_q[0];
	assign m_tlast  = (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= in_seq.count;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seq_q <= in_seq.bytes;
		end else if (take) begin
			for (int k = 0; k < MAX_BYTES - 1; k++) begin
				seq_q[k] <= seq_q[k+1];
			end
			seq_q[MAX_BYTES-1] <= 8'd0;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(MAX_BYTES))
		else $error("byte count beyond the longest encoding");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (cnt_q >= 3'd2) && (cnt_q <= 3'(MAX_BYTES)))
		else $error("loaded encoding has an impossible length");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cnt_q > 3'd1) |=> cnt_q == $past(cnt_q) - 3'd1)
		else $error("byte count did not step down after a byte left");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q > 3'd1) |-> !in_ready)
		else $error("new encoding would overwrite unsent bytes");

endmodule

// ===== src/der_tlv_header_and_integer_encoder_unit.sv =====
// DER header and INTEGER encoder. Each item on the slave side is one of two kinds,
// and s_tuser says which. Mode 0 is a tag plus body length. It becomes the tag byte
// followed by the DER definite length: short form up to 127, otherwise 0x81..0x84
// and one to four big-endian length bytes. Mode 1 is a signed 32-bit value. It
// becomes a complete INTEGER element: 0x02, a count byte, and the minimal
// two's-complement bytes, most significant first. The encoded bytes leave on
// the master side one per cycle while m_tready is held high, in transmission
// order, with tlast on the final byte of each item. An item yields two to six
// bytes; that byte-per-cycle output is what sets the rate. The input is held
// in one register stage, encoded by combinational logic, and loaded into a
// shift buffer in the same cycle the previous item's last byte is taken, so
// items follow each other on the output without a gap. When the pipeline is
// empty, an accepted item passes the input register and is then loaded into
// the shift buffer, whose first byte goes straight to the output.
module der_tlv_header_and_integer_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] tag, [38:8] body_length, [70:39] integer_value, [71] zero
	input  logic [71:0] s_tdata,
	// [0] mode
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] out_byte
	output logic [7:0]  m_tdata,
	// last byte of the item's encoding
	output logic        m_tlast
);
	import dtlv_pkg::*;

	item_t    item_s1;
	logic     valid_s1;
	enc_seq_t seq;
	logic     ser_ready;

	// The input register advances whenever it is empty or its item moves on.
	assign s_tready = !valid_s1 || ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_t'({s_tdata[70:0], s_tuser});
		end
	end

	dtlv_encoder u_encoder (
		.item (item_s1),
		.seq  (seq)
	);

	dtlv_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_ready (ser_ready),
		.in_seq   (seq),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_hold_until_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ser_ready) |=> valid_s1 && $stable(item_s1))
		else $error("held input item lost before the encoder took it");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ser_ready) |-> !s_tready)
		else $error("input accepted while the input register was full");

	a_empty_output: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid && valid_s1) |-> ser_ready)
		else $error("idle output refused a waiting item");

endmodule

// ===== tb/der_stream_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams of the DER encoder, predicts the byte sequence of every
// accepted item and compares each output byte and its tlast flag in order.
module der_stream_checker
	import dtlv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [7:0]           m_tdata,
	input  logic                 m_tlast,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct {
		logic [7:0] value;
		logic       last;
	} enc_byte_t;

	enc_byte_t expected_bytes[$];
	int        error_tally = 0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_tally++;
	endtask

	// Builds the DER bytes of one item and queues them with the last one marked.
	function automatic void predict_encoding(input item_t it);
		logic [7:0]  seq [MAX_BYTES];
		int unsigned cnt;
		int unsigned width;
		logic [31:0] word;
		logic [31:0] magnitude;
		enc_byte_t   eb;
		cnt = 0;
		if (it.mode == MODE_HEADER) begin
			seq[cnt++] = it.tag;
			word = {1'b0, it.body_length};
			if (word <= 32'(SHORT_FORM_MAX)) begin
				seq[cnt++] = word[7:0];
				width = 0;
			end else begin
				if (word > 32'h00ff_ffff)
					width = 4;
				else if (word > 32'h0000_ffff)
					width = 3;
				else if (word > 32'h0000_00ff)
					width = 2;
				else
					width = 1;
				seq[cnt++] = LONG_FORM_BASE | 8'(width);
			end
		end else begin
			word = it.integer_value;
			// A negative value needs as many bytes as its complement does.
			magnitude = word[31] ? ~word : word;
			if (magnitude < 32'h0000_0080)
				width = 1;
			else if (magnitude < 32'h0000_8000)
				width = 2;
			else if (magnitude < 32'h0080_0000)
				width = 3;
			else
				width = 4;
			seq[cnt++] = INTEGER_TAG;
			seq[cnt++] = 8'(width);
		end
		for (int k = int'(width) - 1; k >= 0; k--)
			seq[cnt++] = 8'(word >> (8 * k));
		for (int unsigned i = 0; i < cnt; i++) begin
			eb.value = seq[i];
			eb.last  = (i + 1 == cnt);
			expected_bytes.push_back(eb);
		end
	endfunction

	task automatic check_byte(input logic [7:0] value, input logic last);
		enc_byte_t eb;
		if (expected_bytes.size() == 0) begin
			report_mismatch($sformatf("byte %02h (last %0b) with nothing pending", value, last));
		end else begin
			eb = expected_bytes.pop_front();
			if (value !== eb.value)
				report_mismatch($sformatf("byte %02h, expected %02h", value, eb.value));
			if (last !== eb.last)
				report_mismatch($sformatf("last %0b, expected %0b on byte %02h", last, eb.last,
					eb.value));
		end
	endtask

	// Input side first, so an item and its first byte could share an edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_encoding(item_t'({s_tdata[70:0], s_tuser}));
			if (m_tvalid && m_tready)
				check_byte(m_tdata, m_tlast);
		end
		mismatches  <= error_tally;
		outstanding <= expected_bytes.size();
	end

endmodule

// ===== tb/tb_der_tlv_header_and_integer_encoder_unit.sv =====
`timescale 1ns / 1ps

module tb_der_tlv_header_and_integer_encoder_unit;
	import dtlv_pkg::*;

	// All inputs of the block start at known values before the first edge.
	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;
	logic                 m_tlast;

	int mismatches;
	int outstanding;

	// Receiver stall pattern: a percentage of ready cycles, redrawn whenever the low
	// byte of stall_clock is zero, so that some stretches never stall and others stall heavily.
	logic [15:0] stall_clock = '0;
	int unsigned ready_pct   = 100;

	der_tlv_header_and_integer_encoder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	der_stream_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		stall_clock <= stall_clock + 1'b1;
		if (stall_clock[7:0] == 8'd0) begin
			case ($urandom_range(0, 3))
				0: ready_pct <= 100;
				1: ready_pct <= 80;
				2: ready_pct <= 50;
				default: ready_pct <= 20;
			endcase
		end
		m_tready <= ($urandom_range(1, 100) <= ready_pct);
	end

	// A header item. The integer field is ignored in this mode, so it carries
	// random bits to show that they have no effect.
	function automatic item_t header_item(input logic [7:0] tag, input logic [30:0] len);
		item_t it;
		it.mode          = MODE_HEADER;
		it.tag           = tag;
		it.body_length   = len;
		it.integer_value = $urandom;
		return it;
	endfunction

	// An INTEGER item. Tag and body length are ignored here and hold random bits.
	function automatic item_t integer_item(input logic signed [31:0] value);
		item_t it;
		it.mode          = MODE_INTEGER;
		it.tag           = 8'($urandom);
		it.body_length   = 31'($urandom);
		it.integer_value = value;
		return it;
	endfunction

	// A random item whose value is spread over the byte widths, so that every
	// length form and every integer width turns up often.
	function automatic item_t random_item();
		item_t       it;
		int unsigned width;
		width = $urandom_range(0, 4);
		if ($urandom_range(0, 1) == 0) begin
			it = header_item(8'($urandom), 31'($urandom));
			if (width == 0)
				it.body_length = 31'($urandom_range(0, 127));
			else if (width < 4)
				it.body_length = 31'($urandom >> (32 - 8 * width));
		end else begin
			it = integer_item($urandom);
			// Arithmetic shift keeps the sign and narrows the value to its width.
			if (width != 0)
				it.integer_value = $signed($urandom) >>> (32 - 8 * width);
		end
		return it;
	endfunction

	// Presents one item and holds it until the block takes it. The valid stays
	// high on return, so back-to-back items need no extra edge.
	task automatic send_item(input item_t it);
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, it.integer_value, it.body_length, it.tag};
		s_tuser  <= it.mode;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Idles the sender; the data bus carries junk while valid is low.
	task automatic sender_gap(input int unsigned cycles);
		if (cycles != 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= IN_DATA_W'({$urandom, $urandom, $urandom});
			s_tuser  <= 1'($urandom);
			repeat (cycles) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		item_t       directed[$];
		int unsigned burst_left;
		int unsigned settle;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Length forms: zero, the short-form limit, and both ends of each
		// long-form width up to the largest 31-bit length.
		directed.push_back(header_item(8'h00, 31'd0));
		directed.push_back(header_item(8'hff, 31'd127));
		directed.push_back(header_item(8'h30, 31'd128));
		directed.push_back(header_item(8'h04, 31'd255));
		directed.push_back(header_item(8'ha5, 31'd256));
		directed.push_back(header_item(8'h5a, 31'h0000_ffff));
		directed.push_back(header_item(8'h31, 31'h0001_0000));
		directed.push_back(header_item(8'h80, 31'h00ff_ffff));
		directed.push_back(header_item(8'h01, 31'h0100_0000));
		directed.push_back(header_item(8'h7f, 31'h7fff_ffff));
		// Integer widths: zero and both ends of each signed byte range.
		directed.push_back(integer_item(32'sd0));
		directed.push_back(integer_item(32'sd127));
		directed.push_back(integer_item(32'sd128));
		directed.push_back(integer_item(-32'sd128));
		directed.push_back(integer_item(-32'sd129));
		directed.push_back(integer_item(32'sd32767));
		directed.push_back(integer_item(-32'sd32768));
		directed.push_back(integer_item(32'sd32768));
		directed.push_back(integer_item(-32'sd32769));
		directed.push_back(integer_item(32'sd8388607));
		directed.push_back(integer_item(-32'sd8388608));
		directed.push_back(integer_item(32'sd8388608));
		directed.push_back(integer_item(-32'sd8388609));
		directed.push_back(integer_item(32'sh7fff_ffff));
		directed.push_back(integer_item(32'sh8000_0000));

		foreach (directed[i]) begin
			send_item(directed[i]);
			if ($urandom_range(0, 3) == 0)
				sender_gap($urandom_range(1, 4));
		end

		// Random part in bursts. Items 200 to 299 go out with no gaps at all.
		burst_left = 0;
		for (int n = 0; n < 500; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				if (n < 200 || n >= 300)
					sender_gap($urandom_range(0, 7));
			end
			send_item(random_item());
			burst_left--;
		end
		s_tvalid <= 1'b0;
		// One more edge so that the pending count includes the last item.
		@(posedge clk);

		// Drain every expected byte, then give the block a few more cycles to
		// show any byte it should not send.
		while (outstanding != 0)
			@(posedge clk);
		settle = 16;
		repeat (settle) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin : watchdog
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== der_tlv_header_and_integer_encoder_unit.f =====
src/dtlv_pkg.sv
src/dtlv_encoder.sv
src/dtlv_serializer.sv
src/der_tlv_header_and_integer_encoder_unit.sv
tb/der_stream_checker.sv
tb/tb_der_tlv_header_and_integer_encoder_unit.sv
